// ===== design/vchm_pkg.sv =====
// -----------------------------------------------------------------------------
// vchm_pkg
// Types, codes and the arithmetic step table shared by the voxel hash map.
// -----------------------------------------------------------------------------
package vchm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_FOUND     = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_DUPLICATE = 3'd3,
    STS_RANGE     = 3'd4,
    STS_FULL      = 3'd5
  } status_e;

  localparam logic [2:0] CFG_BATCHES = 3'd0;
  localparam logic [2:0] CFG_DEPTH   = 3'd1;
  localparam logic [2:0] CFG_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_TBL_LG  = 3'd4;

  localparam logic [63:0] MIX1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2 = 64'h94d049bb133111eb;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_XS30,
    DP_XS27,
    DP_XS31,
    DP_HOME,
    DP_READ,
    DP_NEXT,
    DP_WRITE,
    DP_CLR_START,
    DP_CLR
  } dp_op_e;

  typedef enum logic [2:0] {
    OPND_DEPTH,
    OPND_HEIGHT,
    OPND_WIDTH,
    OPND_MIX1,
    OPND_MIX2
  } opnd_e;

  typedef struct packed {
    dp_op_e op;
    opnd_e  opnd;
  } dp_cmd_t;

  typedef struct packed {
    logic        range_ok;
    logic        slot_empty;
    logic        slot_match;
    logic        probe_last;
    logic        clear_last;
    logic [15:0] slot_value;
  } dp_stat_t;

  localparam logic [4:0] CALC_LAST = 5'd18;

  // Linearisation (three multiply-adds) then the 64-bit finaliser, then home slot.
  function automatic dp_cmd_t calc_step(logic [4:0] k);
    dp_cmd_t c;
    c.op   = DP_IDLE;
    c.opnd = OPND_DEPTH;
    unique case (k)
      5'd0:  c = '{DP_MUL0, OPND_DEPTH};
      5'd1:  c = '{DP_MUL1, OPND_DEPTH};
      5'd2:  c = '{DP_MUL2, OPND_DEPTH};
      5'd3:  c = '{DP_MUL0, OPND_HEIGHT};
      5'd4:  c = '{DP_MUL1, OPND_HEIGHT};
      5'd5:  c = '{DP_MUL2, OPND_HEIGHT};
      5'd6:  c = '{DP_MUL0, OPND_WIDTH};
      5'd7:  c = '{DP_MUL1, OPND_WIDTH};
      5'd8:  c = '{DP_MUL2, OPND_WIDTH};
      5'd9:  c = '{DP_XS30, OPND_DEPTH};
      5'd10: c = '{DP_MUL0, OPND_MIX1};
      5'd11: c = '{DP_MUL1, OPND_MIX1};
      5'd12: c = '{DP_MUL2, OPND_MIX1};
      5'd13: c = '{DP_XS27, OPND_DEPTH};
      5'd14: c = '{DP_MUL0, OPND_MIX2};
      5'd15: c = '{DP_MUL1, OPND_MIX2};
      5'd16: c = '{DP_MUL2, OPND_MIX2};
      5'd17: c = '{DP_XS31, OPND_DEPTH};
      5'd18: c = '{DP_HOME, OPND_DEPTH};
      default: c = '{DP_IDLE, OPND_DEPTH};
    endcase
    return c;
  endfunction

endpackage

// ===== design/voxel_coordinate_hash_map.sv =====
// -----------------------------------------------------------------------------
// voxel_coordinate_hash_map
// Open-addressing hash table of 4-D voxel coordinates with linear probing.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   command  | start_i / busy_o   | command_i, coord_*_i, entry_value_i
//   result   | done_o (strobe)    | status_o, found_value_o
//   config   | cfg_we_i           | cfg_index_i, cfg_data_i
//
// Insert/find: the key and hash run as 19 steps on one shared 32x32
// multiplier, and each probe is one registered read of the slot store.
// Clear sweeps all TABLE_SLOTS slots of the store empty.
// After reset the store is swept empty, busy_o high.
// Results are one-cycle strobes; the receiver cannot stall.
// -----------------------------------------------------------------------------
module voxel_coordinate_hash_map #(
  parameter int TABLE_SLOTS = 4096,
  parameter int VALUE_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] coord_batch_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_x_i,
  input  logic [15:0]        entry_value_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [15:0]        found_value_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import vchm_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  vchm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .command_i, .busy_o, .done_o, .status_o,
    .found_value_o, .cmd_o(dp_cmd), .stat_i(dp_stat)
  );

  vchm_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .coord_batch_i, .coord_z_i, .coord_y_i, .coord_x_i, .entry_value_i,
    .cmd_i(dp_cmd), .stat_o(dp_stat)
  );

endmodule

// ===== design/vchm_datapath.sv =====
// -----------------------------------------------------------------------------
// vchm_datapath
// Config registers, key arithmetic on one shared 32x32 multiplier, slot store.
// -----------------------------------------------------------------------------
module vchm_datapath #(
  parameter int TABLE_SLOTS = 4096,
  parameter int VALUE_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [31:0] coord_batch_i,
  input  logic signed [31:0] coord_z_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_x_i,
  input  logic [15:0]        entry_value_i,
  input  vchm_pkg::dp_cmd_t  cmd_i,
  output vchm_pkg::dp_stat_t stat_o
);
  import vchm_pkg::*;

  localparam int AW     = $clog2(TABLE_SLOTS);
  localparam int LG_MAX = $clog2(TABLE_SLOTS + 1) - 1;

  logic [15:0] grid_b_q, grid_d_q, grid_h_q, grid_w_q;
  logic [3:0]  tbl_lg_q;

  logic [31:0] b_q, z_q, y_q, x_q;
  logic [15:0] val_q;
  logic [63:0] v_q, acc_q, key_q;
  logic [AW-1:0] pos_q, clr_q;
  logic [AW:0]   cnt_q;
  logic [63:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;

  logic [63:0] key_mem [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] val_mem [TABLE_SLOTS];

  // Config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_b_q <= 16'd1;
      grid_d_q <= 16'd1;
      grid_h_q <= 16'd1;
      grid_w_q <= 16'd1;
      tbl_lg_q <= 4'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BATCHES: grid_b_q <= cfg_data_i;
        CFG_DEPTH:   grid_d_q <= cfg_data_i;
        CFG_HEIGHT:  grid_h_q <= cfg_data_i;
        CFG_WIDTH:   grid_w_q <= cfg_data_i;
        CFG_TBL_LG:  tbl_lg_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Active table size
  logic [4:0]    lg;
  logic [AW:0]   n_slots;
  logic [AW-1:0] mask;
  always_comb begin
    lg = (tbl_lg_q == 4'd0) ? 5'd1 : {1'b0, tbl_lg_q};
    if (lg > 5'(LG_MAX)) lg = 5'(LG_MAX);
    n_slots = (AW+1)'(1) << lg;
    mask    = AW'(n_slots - (AW+1)'(1));
  end

  function automatic logic in_rng(logic [31:0] c, logic [15:0] ext);
    return !c[31] && (c < {16'd0, ext});
  endfunction

  // Shared multiplier
  logic [63:0] opnd;
  logic [63:0] addend;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    unique case (cmd_i.opnd)
      OPND_DEPTH:  begin opnd = {48'd0, grid_d_q}; addend = {32'd0, z_q}; end
      OPND_HEIGHT: begin opnd = {48'd0, grid_h_q}; addend = {32'd0, y_q}; end
      OPND_WIDTH:  begin opnd = {48'd0, grid_w_q}; addend = {32'd0, x_q} + 64'd1; end
      OPND_MIX1:   begin opnd = MIX1; addend = 64'd0; end
      OPND_MIX2:   begin opnd = MIX2; addend = 64'd0; end
      default:     begin opnd = 64'd0; addend = 64'd0; end
    endcase
    mul_a = (cmd_i.op == DP_MUL2) ? v_q[63:32] : v_q[31:0];
    mul_b = (cmd_i.op == DP_MUL1) ? opnd[63:32] : opnd[31:0];
    prod  = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        b_q   <= coord_batch_i;
        z_q   <= coord_z_i;
        y_q   <= coord_y_i;
        x_q   <= coord_x_i;
        val_q <= entry_value_i;
        v_q   <= {32'd0, coord_batch_i};
      end
      DP_MUL0: acc_q <= prod + addend;
      DP_MUL1: acc_q <= acc_q + {prod[31:0], 32'd0};
      DP_MUL2: v_q   <= acc_q + {prod[31:0], 32'd0};
      DP_XS30: begin
        key_q <= v_q;
        v_q   <= v_q ^ (v_q >> 30);
      end
      DP_XS27: v_q <= v_q ^ (v_q >> 27);
      DP_XS31: v_q <= v_q ^ (v_q >> 31);
      DP_HOME: pos_q <= v_q[AW-1:0] & mask;
      DP_READ: begin
        rd_key_q <= key_mem[pos_q];
        rd_val_q <= val_mem[pos_q];
      end
      DP_NEXT: pos_q <= (pos_q + AW'(1)) & mask;
      default: ;
    endcase
  end

  // Probe count and clear sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.op == DP_HOME) cnt_q <= '0;
      else if (cmd_i.op == DP_NEXT) cnt_q <= cnt_q + (AW+1)'(1);
      if (cmd_i.op == DP_CLR_START) clr_q <= '0;
      else if (cmd_i.op == DP_CLR) clr_q <= clr_q + AW'(1);
    end
  end

  // Slot store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_WRITE) begin
      key_mem[pos_q] <= key_q;
      val_mem[pos_q] <= VALUE_BITS'(val_q);
    end else if (cmd_i.op == DP_CLR) begin
      key_mem[clr_q] <= 64'd0;
    end
  end

  assign stat_o.range_ok   = in_rng(b_q, grid_b_q) && in_rng(z_q, grid_d_q) &&
                             in_rng(y_q, grid_h_q) && in_rng(x_q, grid_w_q);
  assign stat_o.slot_empty = (rd_key_q == 64'd0);
  assign stat_o.slot_match = (rd_key_q == key_q);
  assign stat_o.probe_last = ((cnt_q + (AW+1)'(1)) == n_slots);
  assign stat_o.clear_last = (clr_q == AW'(TABLE_SLOTS - 1));
  assign stat_o.slot_value = 16'(rd_val_q);

endmodule

// ===== design/vchm_ctrl.sv =====
// -----------------------------------------------------------------------------
// vchm_ctrl
// Sequencer: clear sweep, range check, key/hash steps and the probe loop.
// -----------------------------------------------------------------------------
module vchm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         command_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [15:0]        found_value_o,
  output vchm_pkg::dp_cmd_t  cmd_o,
  input  vchm_pkg::dp_stat_t stat_i
);
  import vchm_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_CHECK, ST_CALC, ST_READ, ST_CMP
  } state_e;

  state_e      state_q;
  cmd_e        cmd_q;
  logic [4:0]  step_q;
  logic        done_q;
  status_e     status_q;
  logic [15:0] found_q;

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;

  always_comb begin
    cmd_o = '{DP_IDLE, OPND_DEPTH};
    unique case (state_q)
      ST_INIT, ST_CLEAR: cmd_o.op = DP_CLR;
      ST_IDLE: begin
        if (start_i) begin
          if (cmd_e'(command_i) == CMD_CLEAR) cmd_o.op = DP_CLR_START;
          else if (cmd_e'(command_i) != CMD_NOP) cmd_o.op = DP_LOAD;
        end
      end
      ST_CALC: cmd_o = calc_step(step_q);
      ST_READ: cmd_o.op = DP_READ;
      ST_CMP: begin
        if (stat_i.slot_empty) begin
          if (cmd_q == CMD_INSERT) cmd_o.op = DP_WRITE;
        end else if (!stat_i.slot_match && !stat_i.probe_last) begin
          cmd_o.op = DP_NEXT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cmd_q    <= CMD_NOP;
      step_q   <= '0;
      done_q   <= 1'b0;
      status_q <= STS_DONE;
      found_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_INIT: if (stat_i.clear_last) state_q <= ST_IDLE;
        ST_IDLE: begin
          if (start_i) begin
            cmd_q <= cmd_e'(command_i);
            unique case (cmd_e'(command_i))
              CMD_CLEAR: state_q <= ST_CLEAR;
              CMD_INSERT, CMD_FIND: state_q <= ST_CHECK;
              default: begin
                done_q   <= 1'b1;
                status_q <= STS_DONE;
                found_q  <= '0;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (stat_i.clear_last) begin
            state_q  <= ST_IDLE;
            done_q   <= 1'b1;
            status_q <= STS_DONE;
            found_q  <= '0;
          end
        end
        ST_CHECK: begin
          step_q <= '0;
          if (stat_i.range_ok) begin
            state_q <= ST_CALC;
          end else begin
            state_q  <= ST_IDLE;
            done_q   <= 1'b1;
            status_q <= STS_RANGE;
            found_q  <= '0;
          end
        end
        ST_CALC: begin
          step_q <= step_q + 5'd1;
          if (step_q == CALC_LAST) state_q <= ST_READ;
        end
        ST_READ: state_q <= ST_CMP;
        ST_CMP: begin
          found_q <= '0;
          if (stat_i.slot_empty) begin
            state_q  <= ST_IDLE;
            done_q   <= 1'b1;
            status_q <= (cmd_q == CMD_INSERT) ? STS_DONE : STS_NOT_FOUND;
          end else if (stat_i.slot_match) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            if (cmd_q == CMD_INSERT) begin
              status_q <= STS_DUPLICATE;
            end else begin
              status_q <= STS_FOUND;
              found_q  <= stat_i.slot_value;
            end
          end else if (stat_i.probe_last) begin
            state_q  <= ST_IDLE;
            done_q   <= 1'b1;
            status_q <= (cmd_q == CMD_INSERT) ? STS_FULL : STS_NOT_FOUND;
          end else begin
            state_q <= ST_READ;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/vchm_checker.sv =====
// -----------------------------------------------------------------------------
// vchm_checker
// Port-level checks on the hash map, bound to the top level.
// -----------------------------------------------------------------------------
module vchm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [15:0] found_value_o
);
  import vchm_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= 3'(STS_FULL)))
    else $error("status code out of range");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != 3'(STS_FOUND)) |-> (found_value_o == 16'd0))
    else $error("found value not zero");

  a_transfer_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted transfer ignored");

endmodule

bind voxel_coordinate_hash_map vchm_checker u_vchm_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .status_o, .found_value_o
);
